### src/kts_pkg.sv
// Shared types and constants for the kiln thermostat sequencer.
`default_nettype none

package kts_pkg;

  // Oven mode codes held in the state register
  localparam logic [1:0] MODE_STOPPED = 2'd0;
  localparam logic [1:0] MODE_MANUAL  = 2'd1;
  localparam logic [1:0] MODE_AUTO    = 2'd2;

  // Input item codes
  localparam logic [2:0] CMD_TICK         = 3'd0;
  localparam logic [2:0] CMD_START_MANUAL = 3'd1;
  localparam logic [2:0] CMD_SET_SETPOINT = 3'd2;
  localparam logic [2:0] CMD_START_AUTO   = 3'd3;
  localparam logic [2:0] CMD_STOP         = 3'd4;

  // Configuration register indexes
  localparam logic REG_DURATION = 1'b0;
  localparam logic REG_LOCKOUT  = 1'b1;

  localparam logic [7:0]  LOCKOUT_RESET = 8'd5;
  localparam logic [17:0] SEC_PER_MIN   = 18'd60;
  localparam logic [31:0] RUN_MAX       = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  mode;
    logic [10:0] setpoint;
    logic [17:0] delay_left;
    logic [31:0] run_time;
    logic [7:0]  lockout;
    logic        heat_cmd;
    logic        relay;
    logic        led;
  } kts_state_t;

endpackage

`default_nettype wire

### src/kts_core.sv
// Next-state logic of the thermostat sequencer for one item.
`default_nettype none

module kts_core import kts_pkg::*; (
  input  kts_state_t         state_i,
  input  logic [2:0]         cmd_i,
  input  logic signed [11:0] temperature_i,
  input  logic [10:0]        profile_setpoint_i,
  input  logic [10:0]        manual_setpoint_i,
  input  logic [11:0]        delay_minutes_i,
  input  logic [11:0]        duration_minutes_i,
  input  logic [7:0]         lockout_ticks_i,
  output kts_state_t         state_o
);

  kts_state_t  n;
  logic        stopped;
  logic        do_reg;
  logic        heat_on;
  logic [17:0] duration_sec;
  logic [17:0] delay_sec;

  assign duration_sec = {6'd0, duration_minutes_i} * SEC_PER_MIN;
  assign delay_sec    = {6'd0, delay_minutes_i} * SEC_PER_MIN;
  assign stopped      = (state_i.mode != MODE_MANUAL) && (state_i.mode != MODE_AUTO);

  always_comb begin
    n       = state_i;
    do_reg  = 1'b0;
    heat_on = 1'b0;
    case (cmd_i)
      CMD_TICK: begin
        if (state_i.mode == MODE_MANUAL) begin
          n.led  = ~state_i.led;
          do_reg = 1'b1;
          if (state_i.run_time != RUN_MAX) begin
            n.run_time = state_i.run_time + 32'd1;
          end
        end else if (state_i.mode == MODE_AUTO) begin
          n.led = ~state_i.led;
          if (state_i.delay_left != 18'd0) begin
            n.delay_left = state_i.delay_left - 18'd1;
          end else begin
            // first running tick of the program starts from a clean lockout
            if (state_i.run_time == 32'd0) begin
              n.lockout  = 8'd0;
              n.heat_cmd = 1'b0;
            end
            n.setpoint = profile_setpoint_i;
            do_reg     = 1'b1;
            if (state_i.run_time < {14'd0, duration_sec}) begin
              n.run_time = state_i.run_time + 32'd1;
            end else begin
              n.mode = MODE_STOPPED;
            end
          end
        end else begin
          n.relay = 1'b0;
          n.led   = 1'b0;
        end
      end
      CMD_START_MANUAL: begin
        if (stopped) begin
          n.setpoint = manual_setpoint_i;
          n.run_time = 32'd0;
          n.lockout  = 8'd0;
          n.heat_cmd = 1'b0;
          n.mode     = MODE_MANUAL;
        end
      end
      CMD_SET_SETPOINT: begin
        if (state_i.mode == MODE_MANUAL) begin
          n.setpoint = manual_setpoint_i;
        end
      end
      CMD_START_AUTO: begin
        if (stopped) begin
          n.run_time   = 32'd0;
          n.delay_left = delay_sec;
          n.mode       = MODE_AUTO;
        end
      end
      CMD_STOP: begin
        n.mode = MODE_STOPPED;
      end
      default: begin
      end
    endcase

    // Regulate: evaluate while no lockout is pending, else count it down
    if (do_reg) begin
      if (n.lockout == 8'd0) begin
        heat_on = $signed({temperature_i[11], temperature_i}) < $signed({2'b00, n.setpoint});
        n.relay = heat_on;
        if (n.heat_cmd != heat_on) begin
          n.heat_cmd = heat_on;
          n.lockout  = lockout_ticks_i;
        end
      end else begin
        n.lockout = n.lockout - 8'd1;
      end
    end
  end

  assign state_o = n;

endmodule

`default_nettype wire

### src/kiln_thermostat_sequencer_unit.sv
// Top level of the kiln thermostat sequencer: handshake, registers, state.
//
// Usage: each input transfer on the in_* channel carries one item, a
// one-second tick or a command selected by mode_i. Every item yields exactly
// one result transfer on the out_* channel with the state after that item:
// relay level, LED level, oven mode, run time, remaining start delay and
// the setpoint in force.
// Path: an item is captured in the input register, then the next-state
// logic updates the state register, which drives the result ports.
// Throughput: one item per cycle while the receiver takes each result; the
// loop through the state register is the combinational update of the
// next-state logic.
// When the receiver stalls, the result holds; one more item waits in the
// input register, then in_ready_o drops until the result is taken.
// Reset clears the state to stopped with relay and LED off, program
// duration 0 and lockout 5 ticks. The APB port writes register 0 (program
// duration in minutes) at address 0 and register 1 (lockout ticks) at
// address 4; write it only while the block is idle. pready is always high.
`default_nettype none

module kiln_thermostat_sequencer_unit import kts_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         mode_i,
  input  logic signed [11:0] temperature_i,
  input  logic [10:0]        profile_setpoint_i,
  input  logic [10:0]        manual_setpoint_i,
  input  logic [11:0]        delay_minutes_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               heater_relay_o,
  output logic               run_led_o,
  output logic [1:0]         oven_mode_o,
  output logic [31:0]        run_seconds_o,
  output logic [17:0]        delay_left_seconds_o,
  output logic [10:0]        setpoint_now_o
);

  logic [11:0]        duration_q;
  logic [7:0]         lockout_cfg_q;
  logic               cfg_wr;

  logic               s1_valid_q, s1_valid_d;
  logic [2:0]         s1_cmd_q;
  logic signed [11:0] s1_temp_q;
  logic [10:0]        s1_profile_q;
  logic [10:0]        s1_manual_q;
  logic [11:0]        s1_delay_q;

  logic               out_valid_q, out_valid_d;
  kts_state_t         state_q, state_d;
  logic               advance;
  logic               in_xfer;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duration_q    <= 12'd0;
      lockout_cfg_q <= LOCKOUT_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_DURATION: duration_q    <= pwdata[11:0];
        REG_LOCKOUT:  lockout_cfg_q <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DURATION: prdata = {20'd0, duration_q};
      REG_LOCKOUT:  prdata = {24'd0, lockout_cfg_q};
      default:      prdata = 32'd0;
    endcase
  end

  // Handshake: the state register doubles as the result register
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register: hold the item until it advances
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_cmd_q     <= mode_i;
      s1_temp_q    <= temperature_i;
      s1_profile_q <= profile_setpoint_i;
      s1_manual_q  <= manual_setpoint_i;
      s1_delay_q   <= delay_minutes_i;
    end
  end

  kts_core u_core (
    .state_i            (state_q),
    .cmd_i              (s1_cmd_q),
    .temperature_i      (s1_temp_q),
    .profile_setpoint_i (s1_profile_q),
    .manual_setpoint_i  (s1_manual_q),
    .delay_minutes_i    (s1_delay_q),
    .duration_minutes_i (duration_q),
    .lockout_ticks_i    (lockout_cfg_q),
    .state_o            (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign heater_relay_o       = state_q.relay;
  assign run_led_o            = state_q.led;
  assign oven_mode_o          = state_q.mode;
  assign run_seconds_o        = state_q.run_time;
  assign delay_left_seconds_o = state_q.delay_left;
  assign setpoint_now_o       = state_q.setpoint;

  // Assertions
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while both stages are full and stalled");

  a_result_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result appeared without an item in the input register");

  a_state_held_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(state_q))
    else $error("result state changed while the receiver stalled");

  a_stopped_tick_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_cmd_q == CMD_TICK && state_q.mode == MODE_STOPPED)
      |=> (!state_q.relay && !state_q.led))
    else $error("stopped tick left relay or LED on");

endmodule

`default_nettype wire
